FILE: hdl/gap_pkg.sv
// shared types, constants and neighbour tables for the grid path search block
// no dependencies

package gap_pkg;

  // default sizes
  localparam int GRID_SIDE_DEF  = 32;
  localparam int OPEN_DEPTH_DEF = 1024;

  // cost arithmetic, fixed point times 100
  localparam int          COST_W        = 18;
  localparam logic [17:0] COST_MAX      = 18'h3FFFF;
  localparam logic [17:0] STEP_STRAIGHT = 18'd100;
  localparam logic [17:0] STEP_DIAGONAL = 18'd141;

  // path store and length saturation
  localparam int PATH_DEPTH = 1024;
  localparam int LEN_MAX    = 1023;

  // command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // status codes
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_NO_PATH  = 2'd1;
  localparam logic [1:0] ST_BLOCKED  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // step direction codes
  localparam logic [1:0] DIR_ZERO = 2'd0;
  localparam logic [1:0] DIR_NEG  = 2'd1;
  localparam logic [1:0] DIR_POS  = 2'd2;

  // open list operations
  localparam logic [1:0] HOP_CLEAR = 2'd0;
  localparam logic [1:0] HOP_PUSH  = 2'd1;
  localparam logic [1:0] HOP_POP   = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } heap_req_t;

  typedef struct packed {
    logic done;
    logic overflow;
    logic empty;
  } heap_stat_t;

  // neighbour order: west, east, south, north, then the four diagonals
  function automatic logic [1:0] nb_dx(input logic [2:0] i);
    logic [1:0] d;
    case (i)
      3'd0, 3'd4, 3'd5: d = DIR_NEG;
      3'd1, 3'd6, 3'd7: d = DIR_POS;
      default:          d = DIR_ZERO;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] nb_dy(input logic [2:0] i);
    logic [1:0] d;
    case (i)
      3'd2, 3'd4, 3'd6: d = DIR_NEG;
      3'd3, 3'd5, 3'd7: d = DIR_POS;
      default:          d = DIR_ZERO;
    endcase
    return d;
  endfunction

endpackage

FILE: hdl/grid_astar_path_search_top.sv
// grid A* path search: command decode, cell store, search sequencer, path store
// depends on gap_pkg, gap_cost_unit, gap_heap
// load: result registered on acceptance; read: direct, or through the path store read; search: a
//   clearing pass over 2^(2*ceil(log2 GRID_SIDE)) node entries, then expansions of up to eight
//   neighbours each, plus heap sift steps per level; path build walks the parent chain twice; one
//   command at a time
// reset: a clearing pass over every cell and node entry blocks
//   commands; all cells read as blocked, path count zero

module grid_astar_path_search_top #(
  parameter int GRID_SIDE  = gap_pkg::GRID_SIDE_DEF,
  parameter int OPEN_DEPTH = gap_pkg::OPEN_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] cmd,
  input  logic [4:0] cell_x,
  input  logic [4:0] cell_y,
  input  logic       cell_open,
  input  logic [4:0] src_x,
  input  logic [4:0] src_y,
  input  logic [4:0] dst_x,
  input  logic [4:0] dst_y,
  input  logic [9:0] point_index,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] status,
  output logic [9:0] path_length,
  output logic [4:0] point_x,
  output logic [4:0] point_y
);

  localparam int CW     = $clog2(GRID_SIDE);
  localparam int AW     = 2 * CW;
  localparam int CELLS2 = 1 << AW;
  localparam int CSW    = gap_pkg::COST_W;
  localparam int EW     = CSW + AW;
  localparam int NWD    = 2 + 2 * CSW + AW;
  localparam int F_LO   = AW;
  localparam int G_LO   = AW + CSW;
  localparam int CL_B   = NWD - 2;
  localparam int DS_B   = NWD - 1;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CHK_S = 5'd2;
  localparam logic [4:0] S_CHK_D = 5'd3;
  localparam logic [4:0] S_CHK_E = 5'd4;
  localparam logic [4:0] S_SEED  = 5'd5;
  localparam logic [4:0] S_SEEDW = 5'd6;
  localparam logic [4:0] S_POP   = 5'd7;
  localparam logic [4:0] S_POPW  = 5'd8;
  localparam logic [4:0] S_CRD   = 5'd9;
  localparam logic [4:0] S_CCHK  = 5'd10;
  localparam logic [4:0] S_NB    = 5'd11;
  localparam logic [4:0] S_W1    = 5'd12;
  localparam logic [4:0] S_W2    = 5'd13;
  localparam logic [4:0] S_W3    = 5'd14;
  localparam logic [4:0] S_G     = 5'd15;
  localparam logic [4:0] S_F     = 5'd16;
  localparam logic [4:0] S_UPD   = 5'd17;
  localparam logic [4:0] S_PUSHW = 5'd18;
  localparam logic [4:0] S_PB1   = 5'd19;
  localparam logic [4:0] S_PB2   = 5'd20;
  localparam logic [4:0] S_PB3   = 5'd21;
  localparam logic [4:0] S_PB4   = 5'd22;
  localparam logic [4:0] S_RD    = 5'd23;

  // memories
  logic          walk_mem [CELLS2];
  logic [NWD-1:0] node_mem [CELLS2];
  logic [AW-1:0] path_mem [gap_pkg::PATH_DEPTH];

  logic          walk_rd;
  logic          walk_we;
  logic          walk_wdata;
  logic [AW-1:0] walk_waddr;
  logic [AW-1:0] walk_raddr;
  logic [NWD-1:0] node_rd;
  logic          node_we;
  logic [NWD-1:0] node_wdata;
  logic [AW-1:0] node_waddr;
  logic [AW-1:0] node_raddr;
  logic [AW-1:0] path_rd;
  logic          path_we;
  logic [9:0]    path_waddr;
  logic [9:0]    path_raddr;

  // sequencer registers
  logic [4:0]    state;
  logic          clr_walk;
  logic [AW-1:0] clr_addr;
  logic [CW-1:0] sx, sy, tx, ty;
  logic [CW-1:0] cx, cy, nx, ny;
  logic [2:0]    nb;
  logic [17:0]   gc;
  logic [17:0]   gval;
  logic [17:0]   hval;
  logic          ws, pn, ph, pv;
  logic [NWD-1:0] nw;
  logic [AW-1:0] r;
  logic [AW-1:0] n;
  logic [AW-1:0] k;
  logic [AW-1:0] pcount;

  // shared units
  gap_pkg::heap_req_t  hreq;
  gap_pkg::heap_stat_t hstat;
  logic [EW-1:0]       hent;
  logic [EW-1:0]       htop;
  logic                cu_en;
  logic [17:0]         cu_a, cu_b, cu_sum;

  logic          accept;
  logic [AW-1:0] s_addr, d_addr, n_addr, c_addr;
  logic          nb_ok;
  logic [CW-1:0] nxc, nyc;
  logic [9:0]    len_sat;
  logic [CW-1:0] ddx, ddy;
  logic [CW:0]   manh;
  logic [17:0]   manh18;
  logic [NWD-1:0] eff;
  logic          pass;
  logic          upd;
  logic [AW-1:0] par;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != S_IDLE) || res_valid;
  assign s_addr    = {sy, sx};
  assign d_addr    = {ty, tx};
  assign n_addr    = {ny, nx};
  assign c_addr    = {cy, cx};
  assign par       = node_rd[AW-1:0];
  assign len_sat   = (32'(pcount) > 32'(gap_pkg::LEN_MAX)) ? 10'(gap_pkg::LEN_MAX)
                                                          : 10'(pcount);

  gap_cost_unit u_cost (
    .clk (clk),
    .en  (cu_en),
    .a   (cu_a),
    .b   (cu_b),
    .sum (cu_sum)
  );

  gap_heap #(
    .OPEN_DEPTH (OPEN_DEPTH),
    .EW         (EW)
  ) u_heap (
    .clk     (clk),
    .rst     (rst),
    .req     (hreq),
    .ent_in  (hent),
    .stat    (hstat),
    .top_out (htop)
  );

  // neighbour coordinates and bounds
  always_comb begin
    nb_ok = 1'b1;
    nxc   = cx;
    nyc   = cy;
    case (gap_pkg::nb_dx(nb))
      gap_pkg::DIR_NEG: begin
        nb_ok = (cx != '0);
        nxc   = cx - {{(CW-1){1'b0}}, 1'b1};
      end
      gap_pkg::DIR_POS: begin
        nb_ok = ((32'(cx) + 32'd1) < 32'(GRID_SIDE));
        nxc   = cx + {{(CW-1){1'b0}}, 1'b1};
      end
      default: nxc = cx;
    endcase
    case (gap_pkg::nb_dy(nb))
      gap_pkg::DIR_NEG: begin
        nb_ok = nb_ok && (cy != '0);
        nyc   = cy - {{(CW-1){1'b0}}, 1'b1};
      end
      gap_pkg::DIR_POS: begin
        nb_ok = nb_ok && ((32'(cy) + 32'd1) < 32'(GRID_SIDE));
        nyc   = cy + {{(CW-1){1'b0}}, 1'b1};
      end
      default: nyc = cy;
    endcase
  end

  // manhattan distance to target, times 100 by shifts
  always_comb begin
    ddx    = (nx > tx) ? (nx - tx) : (tx - nx);
    ddy    = (ny > ty) ? (ny - ty) : (ty - ny);
    manh   = {1'b0, ddx} + {1'b0, ddy};
    manh18 = 18'(manh);
  end

  // neighbour node as seen after discovery, and the relax decision
  always_comb begin
    eff = nw;
    if (!nw[DS_B]) begin
      eff = {1'b1, 1'b0, 18'd0, gap_pkg::COST_MAX, n_addr};
    end
    pass = pn && (!nb[2] || (ph && pv));
    upd  = pass && !eff[CL_B] && (eff[F_LO +: CSW] > cu_sum);
  end

  // cost unit operands
  always_comb begin
    cu_en = 1'b0;
    cu_a  = gc;
    cu_b  = nb[2] ? gap_pkg::STEP_DIAGONAL : gap_pkg::STEP_STRAIGHT;
    if (state == S_G) begin
      cu_en = 1'b1;
    end else if (state == S_F) begin
      cu_en = 1'b1;
      cu_a  = cu_sum;
      cu_b  = hval;
    end
  end

  // heap requests
  always_comb begin
    hreq.start = 1'b0;
    hreq.op    = gap_pkg::HOP_CLEAR;
    hent       = {cu_sum, n_addr};
    case (state)
      S_CHK_E: hreq.start = 1'b1;
      S_SEED: begin
        hreq.start = 1'b1;
        hreq.op    = gap_pkg::HOP_PUSH;
        hent       = {18'd0, s_addr};
      end
      S_POP: begin
        hreq.start = !hstat.empty;
        hreq.op    = gap_pkg::HOP_POP;
      end
      S_UPD: begin
        hreq.start = upd;
        hreq.op    = gap_pkg::HOP_PUSH;
      end
      default: hreq.start = 1'b0;
    endcase
  end

  // memory address and write selection
  always_comb begin
    walk_we    = 1'b0;
    walk_wdata = 1'b0;
    walk_waddr = clr_addr;
    walk_raddr = n_addr;
    node_we    = 1'b0;
    node_wdata = '0;
    node_waddr = clr_addr;
    node_raddr = r;
    path_we    = 1'b0;
    path_waddr = 10'(k - {{(AW-1){1'b0}}, 1'b1});
    path_raddr = point_index;
    case (state)
      S_CLR: begin
        walk_we = clr_walk;
        node_we = 1'b1;
      end
      S_IDLE: begin
        walk_we    = accept && (cmd == gap_pkg::CMD_LOAD) &&
                     (32'(cell_x) < 32'(GRID_SIDE)) && (32'(cell_y) < 32'(GRID_SIDE));
        walk_wdata = cell_open;
        walk_waddr = {CW'(cell_y), CW'(cell_x)};
      end
      S_CHK_S: walk_raddr = s_addr;
      S_CHK_D: walk_raddr = d_addr;
      S_SEED: begin
        node_we    = 1'b1;
        node_waddr = s_addr;
        node_wdata = {1'b1, 1'b0, 18'd0, gap_pkg::COST_MAX, s_addr};
      end
      S_CRD:  node_raddr = c_addr;
      S_CCHK: begin
        node_we    = !node_rd[CL_B];
        node_waddr = c_addr;
        node_wdata = node_rd;
        node_wdata[CL_B] = 1'b1;
      end
      S_NB: begin
        walk_raddr = {nyc, nxc};
        node_raddr = {nyc, nxc};
      end
      S_W1: walk_raddr = {cy, nx};
      S_W2: walk_raddr = {ny, cx};
      S_UPD: begin
        node_we    = 1'b1;
        node_waddr = n_addr;
        node_wdata = upd ? {1'b1, eff[CL_B], gval, cu_sum, c_addr} : eff;
      end
      S_PB3: path_we = (k != '0) && ((32'(k) - 32'd1) < 32'(gap_pkg::PATH_DEPTH));
      default: node_raddr = r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (walk_we) walk_mem[walk_waddr] <= walk_wdata;
    walk_rd <= walk_mem[walk_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rd <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_waddr] <= r;
    path_rd <= path_mem[path_raddr];
  end

  // search sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_walk  <= 1'b1;
      clr_addr  <= '0;
      pcount    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            clr_walk <= 1'b0;
            state    <= clr_walk ? S_IDLE : S_SEED;
          end
        end
        S_IDLE: begin
          if (accept) begin
            status      <= gap_pkg::ST_FOUND;
            path_length <= '0;
            point_x     <= '0;
            point_y     <= '0;
            case (cmd)
              gap_pkg::CMD_SEARCH: begin
                sx     <= CW'(src_x);
                sy     <= CW'(src_y);
                tx     <= CW'(dst_x);
                ty     <= CW'(dst_y);
                pcount <= '0;
                if ((src_x == dst_x) && (src_y == dst_y)) begin
                  res_valid <= 1'b1;
                end else if ((32'(src_x) >= 32'(GRID_SIDE)) ||
                             (32'(src_y) >= 32'(GRID_SIDE)) ||
                             (32'(dst_x) >= 32'(GRID_SIDE)) ||
                             (32'(dst_y) >= 32'(GRID_SIDE))) begin
                  status    <= gap_pkg::ST_BLOCKED;
                  res_valid <= 1'b1;
                end else begin
                  state <= S_CHK_S;
                end
              end
              gap_pkg::CMD_READ: begin
                if (32'(point_index) < 32'(pcount)) begin
                  state <= S_RD;
                end else begin
                  path_length <= len_sat;
                  res_valid   <= 1'b1;
                end
              end
              default: res_valid <= 1'b1;
            endcase
          end
        end
        S_RD: begin
          path_length <= len_sat;
          point_x     <= 5'(path_rd[CW-1:0]);
          point_y     <= 5'(path_rd[AW-1:CW]);
          res_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        S_CHK_S: state <= S_CHK_D;
        S_CHK_D: begin
          ws    <= walk_rd;
          state <= S_CHK_E;
        end
        S_CHK_E: begin
          if (!ws || !walk_rd) begin
            status    <= gap_pkg::ST_BLOCKED;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            clr_addr <= '0;
            state    <= S_CLR;
          end
        end
        S_SEED: state <= S_SEEDW;
        S_SEEDW: begin
          if (hstat.done) state <= S_POP;
        end
        S_POP: begin
          if (hstat.empty) begin
            status    <= gap_pkg::ST_NO_PATH;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_POPW;
          end
        end
        S_POPW: begin
          if (hstat.done) begin
            cx    <= htop[CW-1:0];
            cy    <= htop[AW-1:CW];
            state <= S_CRD;
          end
        end
        S_CRD: state <= S_CCHK;
        S_CCHK: begin
          if (node_rd[CL_B]) begin
            state <= S_POP;
          end else begin
            gc <= node_rd[G_LO +: CSW];
            if (c_addr == d_addr) begin
              r     <= d_addr;
              n     <= '0;
              state <= S_PB1;
            end else begin
              nb    <= '0;
              state <= S_NB;
            end
          end
        end
        S_NB: begin
          if (nb_ok) begin
            nx    <= nxc;
            ny    <= nyc;
            state <= S_W1;
          end else if (nb == 3'd7) begin
            state <= S_POP;
          end else begin
            nb <= nb + 3'd1;
          end
        end
        S_W1: begin
          nw <= node_rd;
          pn <= walk_rd && (n_addr != s_addr);
          if (nb[2]) begin
            state <= S_W2;
          end else begin
            ph    <= 1'b1;
            pv    <= 1'b1;
            state <= S_G;
          end
        end
        S_W2: begin
          ph    <= walk_rd && ({cy, nx} != s_addr);
          state <= S_W3;
        end
        S_W3: begin
          pv    <= walk_rd && ({ny, cx} != s_addr);
          state <= S_G;
        end
        S_G: begin
          hval  <= (manh18 << 6) + (manh18 << 5) + (manh18 << 2);
          state <= S_F;
        end
        S_F: begin
          gval  <= cu_sum;
          state <= S_UPD;
        end
        S_UPD: begin
          if (upd) begin
            state <= S_PUSHW;
          end else if (nb == 3'd7) begin
            state <= S_POP;
          end else begin
            nb    <= nb + 3'd1;
            state <= S_NB;
          end
        end
        S_PUSHW: begin
          if (hstat.done) begin
            if (hstat.overflow) begin
              status    <= gap_pkg::ST_OVERFLOW;
              res_valid <= 1'b1;
              state     <= S_IDLE;
            end else if (nb == 3'd7) begin
              state <= S_POP;
            end else begin
              nb    <= nb + 3'd1;
              state <= S_NB;
            end
          end
        end
        // first walk up the parent chain counts the points
        S_PB1: state <= S_PB2;
        S_PB2: begin
          if (par == r) begin
            pcount <= n;
            k      <= n;
            r      <= d_addr;
            state  <= S_PB3;
          end else begin
            n     <= n + 1'b1;
            r     <= par;
            state <= S_PB1;
          end
        end
        // second walk stores them from the last point back
        S_PB3: begin
          if (k == '0) begin
            status      <= gap_pkg::ST_FOUND;
            path_length <= len_sat;
            res_valid   <= 1'b1;
            state       <= S_IDLE;
          end else begin
            state <= S_PB4;
          end
        end
        S_PB4: begin
          r     <= par;
          k     <= k - 1'b1;
          state <= S_PB3;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/gap_cost_unit.sv
// shared saturating cost adder, result registered
// depends on gap_pkg

module gap_cost_unit (
  input  logic        clk,
  input  logic        en,
  input  logic [17:0] a,
  input  logic [17:0] b,
  output logic [17:0] sum
);

  logic [18:0] raw;

  // add and clamp at the cost ceiling
  assign raw = {1'b0, a} + {1'b0, b};

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= (raw > {1'b0, gap_pkg::COST_MAX}) ? gap_pkg::COST_MAX : raw[17:0];
    end
  end

endmodule

FILE: hdl/gap_heap.sv
// open list: binary min-heap in a memory with one read and one write port, one operation at a time
// depends on gap_pkg

module gap_heap #(
  parameter int OPEN_DEPTH = gap_pkg::OPEN_DEPTH_DEF,
  parameter int EW         = 28
) (
  input  logic                clk,
  input  logic                rst,
  input  gap_pkg::heap_req_t  req,
  input  logic [EW-1:0]       ent_in,
  output gap_pkg::heap_stat_t stat,
  output logic [EW-1:0]       top_out
);

  localparam int HW = $clog2(OPEN_DEPTH);

  localparam logic [2:0] H_IDLE   = 3'd0;
  localparam logic [2:0] H_PU_RD  = 3'd1;
  localparam logic [2:0] H_PU_CMP = 3'd2;
  localparam logic [2:0] H_PO_1   = 3'd3;
  localparam logic [2:0] H_PO_2   = 3'd4;
  localparam logic [2:0] H_SD_L   = 3'd5;
  localparam logic [2:0] H_SD_R   = 3'd6;
  localparam logic [2:0] H_SD_C   = 3'd7;

  logic [EW-1:0] mem [OPEN_DEPTH];
  logic [EW-1:0] rd;
  logic [HW-1:0] raddr;
  logic          we;
  logic [HW-1:0] waddr;
  logic [EW-1:0] wdata;

  logic [2:0]    state;
  logic [HW:0]   count;
  logic [HW-1:0] i;
  logic [HW-1:0] p;
  logic [EW-1:0] ent;
  logic [EW-1:0] lent;
  logic          r_ok;
  logic          done;
  logic          ovf;

  logic [HW:0]   l_w;
  logic [HW+1:0] r_w;
  logic [HW-1:0] par_w;
  logic [HW-1:0] m_sel;
  logic [EW-1:0] best;
  logic          moved;

  assign l_w   = {i, 1'b1};
  assign r_w   = {1'b0, l_w} + {{(HW+1){1'b0}}, 1'b1};
  assign par_w = (i - {{(HW-1){1'b0}}, 1'b1}) >> 1;

  // smallest of hole entry and the children
  always_comb begin
    m_sel = i;
    best  = ent;
    moved = 1'b0;
    if (lent < best) begin
      m_sel = l_w[HW-1:0];
      best  = lent;
      moved = 1'b1;
    end
    if (r_ok && (rd < best)) begin
      m_sel = r_w[HW-1:0];
      best  = rd;
      moved = 1'b1;
    end
  end

  // memory addresses and writes
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = i;
    wdata = ent;
    case (state)
      H_IDLE:   raddr = '0;
      H_PU_RD: begin
        raddr = par_w;
        we    = (i == '0);
      end
      H_PU_CMP: begin
        we = 1'b1;
        if (ent < rd) wdata = rd;
      end
      H_PO_1:   raddr = HW'(count - {{HW{1'b0}}, 1'b1});
      H_SD_L: begin
        raddr = l_w[HW-1:0];
        we    = (l_w >= count);
      end
      H_SD_R:   raddr = r_w[HW-1:0];
      H_SD_C: begin
        we    = 1'b1;
        wdata = best;
      end
      default:  raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  // heap sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      count <= '0;
      done  <= 1'b0;
      ovf   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        H_IDLE: begin
          if (req.start) begin
            case (req.op)
              gap_pkg::HOP_CLEAR: begin
                count <= '0;
                ovf   <= 1'b0;
                done  <= 1'b1;
              end
              gap_pkg::HOP_PUSH: begin
                if (32'(count) >= 32'(OPEN_DEPTH)) begin
                  ovf  <= 1'b1;
                  done <= 1'b1;
                end else begin
                  ovf   <= 1'b0;
                  ent   <= ent_in;
                  i     <= count[HW-1:0];
                  count <= count + 1'b1;
                  state <= H_PU_RD;
                end
              end
              gap_pkg::HOP_POP: begin
                ovf   <= 1'b0;
                state <= H_PO_1;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        H_PU_RD: begin
          if (i == '0) begin
            done  <= 1'b1;
            state <= H_IDLE;
          end else begin
            p     <= par_w;
            state <= H_PU_CMP;
          end
        end
        H_PU_CMP: begin
          if (ent < rd) begin
            i     <= p;
            state <= H_PU_RD;
          end else begin
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        H_PO_1: begin
          top_out <= rd;
          count   <= count - 1'b1;
          state   <= H_PO_2;
        end
        H_PO_2: begin
          ent   <= rd;
          i     <= '0;
          state <= H_SD_L;
        end
        H_SD_L: begin
          if (l_w >= count) begin
            done  <= 1'b1;
            state <= H_IDLE;
          end else begin
            state <= H_SD_R;
          end
        end
        H_SD_R: begin
          lent  <= rd;
          r_ok  <= (r_w < {1'b0, count});
          state <= H_SD_C;
        end
        H_SD_C: begin
          if (moved) begin
            i     <= m_sel;
            state <= H_SD_L;
          end else begin
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  assign stat.done     = done;
  assign stat.overflow = ovf;
  assign stat.empty    = (count == '0);

endmodule
